FILE: design/grs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grs_pkg - shared types and constants for the group reverse stream
// Word layouts, buffer geometry and the command passed from front to back.
// ----------------------------------------------------------------------------
package grs_pkg;

  localparam int MAX_GROUP = 16;
  localparam int GRP_W     = $clog2(MAX_GROUP);
  localparam int CNT_W     = $clog2(MAX_GROUP + 1);
  localparam int BANKS     = 2;
  localparam int BANK_W    = 1;
  localparam int ADDR_W    = BANK_W + GRP_W;
  localparam int DEPTH     = BANKS * MAX_GROUP;
  localparam int CFG_W     = 5;
  localparam int DATA_W    = 32;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     final_element;
  } in_word_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] out_value;
    logic                     run_end;
    logic                     sequence_end;
  } out_word_t;

  // One closed group waiting to be drained
  typedef struct packed {
    logic [BANK_W-1:0] bank;
    logic [CNT_W-1:0]  count;
    logic              reverse;
    logic              seq_end;
  } cmd_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
  } wr_port_t;

  typedef struct packed {
    logic              valid;
    logic [BANK_W-1:0] bank;
  } done_t;

  // Zero reads as one, oversize saturates at MAX_GROUP
  function automatic logic [CNT_W-1:0] eff_size(input logic [CFG_W-1:0] gs);
    logic [CNT_W+CFG_W-1:0] gx;
    gx = {{CNT_W{1'b0}}, gs};
    if (gx == '0) begin
      return CNT_W'(1);
    end else if (gx > (CNT_W+CFG_W)'(MAX_GROUP)) begin
      return CNT_W'(MAX_GROUP);
    end
    return CNT_W'(gx);
  endfunction

endpackage

FILE: design/grs_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grs_front - intake and grouping
// Writes each word into the current bank and closes a group when it is full
// or the sequence ends.
// ----------------------------------------------------------------------------
module grs_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [grs_pkg::CFG_W-1:0]   cfg_wr_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  grs_pkg::in_word_t           in_data,
  output grs_pkg::wr_port_t           wr,
  output logic                        push,
  output grs_pkg::cmd_t               push_cmd,
  input  logic                        q_full,
  input  grs_pkg::done_t              done
);
  import grs_pkg::*;

  logic [CFG_W-1:0]  group_size;
  logic [CNT_W-1:0]  fill;
  logic [BANK_W-1:0] wr_bank;
  logic [BANKS-1:0]  busy;
  logic [BANKS-1:0]  busy_next;

  logic             accept;
  logic [CNT_W-1:0] n;
  logic             full_grp;
  logic             close;

  assign in_ready = !busy[wr_bank] && !q_full;
  assign accept   = in_valid && in_ready;
  assign n        = fill + CNT_W'(1);
  assign full_grp = n >= eff_size(group_size);
  assign close    = accept && (full_grp || in_data.final_element);

  assign wr.en   = accept;
  assign wr.addr = {wr_bank, fill[GRP_W-1:0]};
  assign wr.data = in_data.value;

  assign push             = close;
  assign push_cmd.bank    = wr_bank;
  assign push_cmd.count   = n;
  assign push_cmd.reverse = full_grp;
  assign push_cmd.seq_end = in_data.final_element;

  always_comb begin
    busy_next = busy;
    if (done.valid) begin
      busy_next[done.bank] = 1'b0;
    end
    if (close) begin
      busy_next[wr_bank] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      group_size <= CFG_W'(1);
      fill       <= '0;
      wr_bank    <= '0;
      busy       <= '0;
    end else begin
      if (cfg_wr_en) begin
        group_size <= cfg_wr_data;
      end
      if (accept) begin
        if (close) begin
          fill    <= '0;
          wr_bank <= ~wr_bank;
        end else begin
          fill <= n;
        end
      end
      busy <= busy_next;
    end
  end

  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill < CNT_W'(MAX_GROUP))
    else $error("fill count reached buffer depth");

  a_close_swap: assert property (@(posedge clk) disable iff (rst)
    close |=> (fill == '0) && (wr_bank != $past(wr_bank)) && busy[$past(wr_bank)])
    else $error("closed group did not swap banks");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_full)
    else $error("group closed into a full command queue");

endmodule

FILE: design/grs_cmd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grs_cmd_queue - two-entry command queue
// Decouples group closing from group draining.
// ----------------------------------------------------------------------------
module grs_cmd_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  grs_pkg::cmd_t push_cmd,
  input  logic          pop,
  output grs_pkg::cmd_t head,
  output logic          empty,
  output logic          full
);
  import grs_pkg::*;

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign head  = slots[rd_ptr];
  assign empty = (count == 2'd0);
  assign full  = (count == 2'd2);

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

FILE: design/grs_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grs_back - group buffer and drain sequencer
// Holds both banks and replays a closed group forward or reversed.
// ----------------------------------------------------------------------------
module grs_back (
  input  logic               clk,
  input  logic               rst,
  input  grs_pkg::wr_port_t  wr,
  input  grs_pkg::cmd_t      head,
  input  logic               q_empty,
  output logic               pop,
  output grs_pkg::done_t     done,
  output logic               out_valid,
  input  logic               out_ready,
  output grs_pkg::out_word_t out_data
);
  import grs_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];

  logic             active;
  cmd_t             cmd;
  logic [CNT_W-1:0] idx;

  logic              rd_valid;
  logic [DATA_W-1:0] rd_value;
  logic              rd_run_end;
  logic              rd_seq_end;

  logic              rd_move;
  logic              pipe_free;
  logic              issue;
  logic              last_issue;
  logic [CNT_W-1:0]  offset;
  logic [ADDR_W-1:0] rd_addr;

  assign rd_move    = rd_valid && (!out_valid || out_ready);
  assign pipe_free  = !rd_valid || rd_move;
  assign issue      = active && pipe_free;
  assign last_issue = (idx + CNT_W'(1)) == cmd.count;
  assign offset     = cmd.reverse ? (cmd.count - CNT_W'(1) - idx) : idx;
  assign rd_addr    = {cmd.bank, offset[GRP_W-1:0]};
  assign pop        = !active && !q_empty;

  assign done.valid = issue && last_issue;
  assign done.bank  = cmd.bank;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (issue) begin
      rd_value <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_run_end <= last_issue;
      rd_seq_end <= last_issue && cmd.seq_end;
    end
    if (rd_move) begin
      out_data.out_value    <= rd_value;
      out_data.run_end      <= rd_run_end;
      out_data.sequence_end <= rd_seq_end;
    end
    if (pop) begin
      cmd <= head;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      idx       <= '0;
      rd_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        active <= 1'b1;
        idx    <= '0;
      end else if (issue) begin
        idx <= idx + CNT_W'(1);
        if (last_issue) begin
          active <= 1'b0;
        end
      end
      if (issue) begin
        rd_valid <= 1'b1;
      end else if (rd_move) begin
        rd_valid <= 1'b0;
      end
      if (rd_move) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    active |-> (idx < cmd.count))
    else $error("drain index past group length");

  a_last_stop: assert property (@(posedge clk) disable iff (rst)
    (issue && last_issue) |=> !active)
    else $error("sequencer still active after last read");

  a_rd_hold: assert property (@(posedge clk) disable iff (rst)
    (rd_valid && !rd_move) |=> rd_valid && $stable(rd_value))
    else $error("read stage lost a stalled word");

endmodule

FILE: design/group_reverse_stream.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// group_reverse_stream - reverse a stream of words in groups of group_size
// Full groups leave reversed, a trailing partial group leaves in order.
// ----------------------------------------------------------------------------
//
//   channel  | signals                         | direction | handshake
//   ---------+---------------------------------+-----------+----------------
//   input    | in_valid in_ready in_data       | in        | valid/ready
//   output   | out_valid out_ready out_data    | out       | valid/ready
//   config   | cfg_wr_en cfg_wr_data           | in        | write strobe
//
// Cycles: the front takes one word per cycle while its current bank is free.
//   A closed group drains by first loading the command, then one buffer
//   read per word, so the sustained rate is set by the single read port of
//   the group buffer.
// Stalls: two banks alternate; the front stalls only when it would write a
//   bank still waiting to drain. out_ready low holds the output register and
//   the read stage behind it.
// Reset: synchronous; clears fill count, banks, queue and valids, and sets
//   group_size to 1. The buffer is not cleared; only written entries are read.
//
module group_reverse_stream (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wr_en,
  input  logic [grs_pkg::CFG_W-1:0]  cfg_wr_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  grs_pkg::in_word_t          in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output grs_pkg::out_word_t         out_data
);
  import grs_pkg::*;

  // Front to buffer write port, and close-group commands into the queue
  wr_port_t wr;
  logic     push;
  cmd_t     push_cmd;

  // Queue head toward the drain side
  cmd_t     head;
  logic     q_empty;
  logic     q_full;
  logic     pop;

  // Drain side frees a bank once its last word is read
  done_t    done;

  grs_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .wr          (wr),
    .push        (push),
    .push_cmd    (push_cmd),
    .q_full      (q_full),
    .done        (done)
  );

  grs_cmd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  grs_back u_back (
    .clk       (clk),
    .rst       (rst),
    .wr        (wr),
    .head      (head),
    .q_empty   (q_empty),
    .pop       (pop),
    .done      (done),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
